// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// ===== rtl/tkesc_pkg.sv =====
`timescale 1ns / 1ps

package tkesc_pkg;

    localparam int TIME_BITS  = 32;
    localparam int COUNT_BITS = 17;
    localparam int TMO_BITS   = 16;
    localparam int MAXE_BITS  = 4;
    localparam int THR_BITS   = 17;
    localparam int CFG_BITS   = 17;
    localparam int LVL_BITS   = 4;

    localparam int CMP_A   = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
    localparam int CMP_BITS = (CMP_A > THR_BITS) ? CMP_A : THR_BITS;

    localparam logic [2:0] OP_REQUEST = 3'd0;
    localparam logic [2:0] OP_TICK    = 3'd1;
    localparam logic [2:0] OP_ACK     = 3'd2;
    localparam logic [2:0] OP_CANCEL  = 3'd3;
    localparam logic [2:0] OP_FORCE   = 3'd4;
    localparam logic [2:0] OP_RESET   = 3'd5;

    localparam logic [1:0] CFG_TIMEOUT   = 2'd0;
    localparam logic [1:0] CFG_MAX_ESC   = 2'd1;
    localparam logic [1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [2:0] URG_NONE      = 3'd0;
    localparam logic [2:0] URG_ADVISORY  = 3'd1;
    localparam logic [2:0] URG_WARNING   = 3'd2;
    localparam logic [2:0] URG_IMMEDIATE = 3'd3;
    localparam logic [2:0] URG_CRITICAL  = 3'd4;

    localparam logic [2:0] CODE_INACTIVE  = 3'd0;
    localparam logic [2:0] CODE_PREWARN   = 3'd1;
    localparam logic [2:0] CODE_REQUEST   = 3'd2;
    localparam logic [2:0] CODE_ESCALATED = 3'd3;
    localparam logic [2:0] CODE_CRITICAL  = 3'd4;
    localparam logic [2:0] CODE_SAFESTOP  = 3'd5;
    localparam logic [2:0] CODE_COMPLETED = 3'd6;

    typedef enum logic [6:0] {
        ST_INACTIVE  = 7'b0000001,
        ST_PREWARN   = 7'b0000010,
        ST_REQUEST   = 7'b0000100,
        ST_ESCALATED = 7'b0001000,
        ST_CRITICAL  = 7'b0010000,
        ST_SAFESTOP  = 7'b0100000,
        ST_COMPLETED = 7'b1000000
    } t_state;

    function automatic logic [2:0] state_code(input t_state st);
        logic [2:0] code;
        unique case (st)
            ST_PREWARN:   code = CODE_PREWARN;
            ST_REQUEST:   code = CODE_REQUEST;
            ST_ESCALATED: code = CODE_ESCALATED;
            ST_CRITICAL:  code = CODE_CRITICAL;
            ST_SAFESTOP:  code = CODE_SAFESTOP;
            ST_COMPLETED: code = CODE_COMPLETED;
            default:      code = CODE_INACTIVE;
        endcase
        return code;
    endfunction

    function automatic logic [2:0] state_urgency(input t_state st);
        logic [2:0] urg;
        unique case (st)
            ST_PREWARN:   urg = URG_ADVISORY;
            ST_REQUEST:   urg = URG_WARNING;
            ST_ESCALATED: urg = URG_IMMEDIATE;
            ST_CRITICAL:  urg = URG_CRITICAL;
            ST_SAFESTOP:  urg = URG_CRITICAL;
            default:      urg = URG_NONE;
        endcase
        return urg;
    endfunction

endpackage

// ===== rtl/takeover_escalation_fsm.sv =====
`timescale 1ns / 1ps
// Takeover escalation controller. Each event word (request, tick, acknowledge, cancel,
// force safe stop, reset) yields exactly one result word with the state, derived urgency,
// remaining countdown, escalation level and alert flags after the event. An event is
// registered on entry and processed from the input register by a single pass of subtract,
// compare and select logic into the result register, so the block takes one event per
// cycle; the only limit on throughput is downstream stall, which holds both registers.
// Configuration registers (timeout, max level, critical threshold) are always ready and
// are to be written only while no event is in flight.

`include "assert_macros.svh"

module takeover_escalation_fsm (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [2:0]                          i_op,
    input  logic [tkesc_pkg::TIME_BITS-1:0]     i_time_ms,
    input  logic                                i_req_active,
    input  logic [2:0]                          i_req_urgency,
    input  logic [tkesc_pkg::COUNT_BITS-1:0]    i_req_countdown_ms,
    input  logic                                i_req_audio,
    input  logic                                i_req_haptic,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [2:0]                          o_fsm_state,
    output logic [2:0]                          o_urgency,
    output logic [tkesc_pkg::COUNT_BITS-1:0]    o_remaining_ms,
    output logic [tkesc_pkg::LVL_BITS-1:0]      o_escalation_level,
    output logic                                o_audio_on,
    output logic                                o_haptic_on,
    output logic                                o_takeover_active,
    output logic                                o_safe_stop_active,
    output logic                                o_immediate_action,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [1:0]                          i_cfg_index,
    input  logic [tkesc_pkg::CFG_BITS-1:0]      i_cfg_data
);
    import tkesc_pkg::*;

    logic [TMO_BITS-1:0]   r_timeout;
    logic [MAXE_BITS-1:0]  r_max_esc;
    logic [THR_BITS-1:0]   r_threshold;

    logic                  r_in_valid;
    logic [2:0]            r_op;
    logic [TIME_BITS-1:0]  r_time;
    logic                  r_req_active;
    logic [2:0]            r_req_urgency;
    logic [COUNT_BITS-1:0] r_req_cd;
    logic                  r_req_audio;
    logic                  r_req_haptic;

    t_state                r_state, n_state;
    logic [COUNT_BITS-1:0] r_remaining, n_remaining;
    logic [COUNT_BITS-1:0] r_init, n_init;
    logic [TIME_BITS-1:0]  r_cstart, n_cstart;
    logic [TIME_BITS-1:0]  r_last, n_last;
    logic [LVL_BITS-1:0]   r_level, n_level;
    logic                  r_audio, n_audio;
    logic                  r_haptic, n_haptic;

    logic                  r_out_valid;

    logic                  w_adv;
    logic                  w_goto;
    t_state                w_target;
    logic [TIME_BITS-1:0]  w_elapsed;
    logic [TIME_BITS-1:0]  w_since;
    logic [COUNT_BITS-1:0] w_rem_tick;
    logic [2:0]            w_urg;

    assign w_adv       = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && r_out_valid && i_stall;
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= TMO_BITS'(3000);
            r_max_esc   <= MAXE_BITS'(3);
            r_threshold <= THR_BITS'(5000);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TIMEOUT:   r_timeout   <= i_cfg_data[TMO_BITS-1:0];
                CFG_MAX_ESC:   r_max_esc   <= i_cfg_data[MAXE_BITS-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_BITS-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_op          <= i_op;
            r_time        <= i_time_ms;
            r_req_active  <= i_req_active;
            r_req_urgency <= i_req_urgency;
            r_req_cd      <= i_req_countdown_ms;
            r_req_audio   <= i_req_audio;
            r_req_haptic  <= i_req_haptic;
        end
    end

    assign w_elapsed = r_time - r_cstart;
    assign w_since   = r_time - r_last;

    always_comb begin
        if (CMP_BITS'(r_init) > CMP_BITS'(w_elapsed)) begin
            w_rem_tick = COUNT_BITS'(CMP_BITS'(r_init) - CMP_BITS'(w_elapsed));
        end else begin
            w_rem_tick = '0;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_remaining = r_remaining;
        n_init      = r_init;
        n_cstart    = r_cstart;
        n_last      = r_last;
        n_level     = r_level;
        n_audio     = r_audio;
        n_haptic    = r_haptic;
        w_goto      = 1'b0;
        w_target    = r_state;

        unique case (r_op)
            OP_REQUEST: begin
                if (!r_req_active) begin
                    w_goto   = (r_state != ST_INACTIVE) && (r_state != ST_COMPLETED);
                    w_target = ST_INACTIVE;
                end else begin
                    n_init      = r_req_cd;
                    n_remaining = r_req_cd;
                    n_cstart    = r_time;
                    n_last      = r_time;
                    n_audio     = r_req_audio;
                    n_haptic    = r_req_haptic;
                    w_goto      = 1'b1;
                    case (r_req_urgency)
                        URG_ADVISORY:  w_target = ST_PREWARN;
                        URG_WARNING:   w_target = ST_REQUEST;
                        URG_IMMEDIATE: w_target = ST_ESCALATED;
                        URG_CRITICAL:  w_target = ST_CRITICAL;
                        default:       w_goto   = 1'b0;
                    endcase
                end
            end
            OP_TICK: begin
                if (r_state != ST_INACTIVE && r_state != ST_COMPLETED &&
                    r_state != ST_SAFESTOP) begin
                    if (r_init != '0) begin
                        n_remaining = w_rem_tick;
                    end
                    if (r_init != '0 && w_rem_tick == '0) begin
                        w_goto   = 1'b1;
                        w_target = ST_SAFESTOP;
                    end else if (w_since > TIME_BITS'(r_timeout) && r_level < r_max_esc) begin
                        n_level  = r_level + 1'b1;
                        n_last   = r_time;
                        n_audio  = 1'b1;
                        n_haptic = 1'b1;
                        w_goto   = 1'b1;
                        unique case (r_state)
                            ST_PREWARN:   w_target = ST_REQUEST;
                            ST_REQUEST:   w_target = ST_ESCALATED;
                            ST_ESCALATED: w_target = ST_CRITICAL;
                            default:      w_target = ST_SAFESTOP;
                        endcase
                    end else if (CMP_BITS'(n_remaining) <= CMP_BITS'(r_threshold) &&
                                 r_state != ST_CRITICAL) begin
                        w_goto   = 1'b1;
                        w_target = ST_CRITICAL;
                    end
                end
            end
            OP_ACK: begin
                w_goto   = 1'b1;
                w_target = ST_COMPLETED;
            end
            OP_CANCEL: begin
                w_goto   = 1'b1;
                w_target = ST_INACTIVE;
            end
            OP_FORCE: begin
                w_goto   = 1'b1;
                w_target = ST_SAFESTOP;
            end
            OP_RESET: begin
                n_state     = ST_INACTIVE;
                n_remaining = '0;
                n_init      = '0;
                n_level     = '0;
                n_audio     = 1'b0;
                n_haptic    = 1'b0;
            end
            default: ;
        endcase

        if (w_goto && w_target != r_state) begin
            n_state = w_target;
            if (w_target == ST_INACTIVE || w_target == ST_COMPLETED) begin
                n_level  = '0;
                n_audio  = 1'b0;
                n_haptic = 1'b0;
            end
        end
    end

    assign w_urg = state_urgency(n_state);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INACTIVE;
            r_remaining <= '0;
            r_init      <= '0;
            r_cstart    <= '0;
            r_last      <= '0;
            r_level     <= '0;
            r_audio     <= 1'b0;
            r_haptic    <= 1'b0;
        end else if (w_adv) begin
            r_state     <= n_state;
            r_remaining <= n_remaining;
            r_init      <= n_init;
            r_cstart    <= n_cstart;
            r_last      <= n_last;
            r_level     <= n_level;
            r_audio     <= n_audio;
            r_haptic    <= n_haptic;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            o_fsm_state        <= state_code(n_state);
            o_urgency          <= w_urg;
            o_remaining_ms     <= n_remaining;
            o_escalation_level <= n_level;
            o_audio_on         <= n_audio;
            o_haptic_on        <= n_haptic;
            o_takeover_active  <= (n_state != ST_INACTIVE) && (n_state != ST_COMPLETED);
            o_safe_stop_active <= (n_state == ST_SAFESTOP);
            o_immediate_action <= (w_urg >= URG_IMMEDIATE) ||
                                  (CMP_BITS'(n_remaining) <= CMP_BITS'(r_threshold));
        end
    end

    `ASSERT_IMPLY(a_idle_level_zero, i_clk, i_rst_n,
        o_valid && !o_takeover_active, o_escalation_level == '0)
    `ASSERT_IMPLY(a_safestop_critical, i_clk, i_rst_n,
        o_valid && o_safe_stop_active, o_urgency == URG_CRITICAL)
    `ASSERT_IMPLY(a_level_step, i_clk, i_rst_n,
        r_level != $past(r_level), r_level == $past(r_level) + 1'b1 || r_level == '0)
    `ASSERT_IMPLY(a_state_only_on_advance, i_clk, i_rst_n,
        $past(i_rst_n) && !$past(w_adv), $stable(r_state) && $stable(r_level))

endmodule
